@@ rtl/cdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdc_pkg
// Shared types, constants and constant-divisor helpers for the calendar date
// and day number converter.
// ----------------------------------------------------------------------------
package cdc_pkg;

  localparam logic FUNC_DATE_TO_JD = 1'b0;
  localparam logic FUNC_JD_TO_DATE = 1'b1;

  localparam logic [22:0] GREG_START_JD  = 23'd2299161;
  localparam logic [22:0] MAX_DAY_NUMBER = 23'd5373484;

  // Stage counts of the two halves of the datapath.
  localparam int FRONT_STAGES = 5;
  localparam int BACK_STAGES  = 4;
  localparam int NUM_STAGES   = FRONT_STAGES + BACK_STAGES;

  // Reciprocals for exact floor division of an n-bit value by a constant:
  // shift = n + clog2(divisor), factor = ceil(2^shift / divisor).
  localparam int K_146097 = 26 + $clog2(146097);
  localparam longint unsigned M_146097 =
      ((64'd1 << K_146097) + 64'd146096) / 64'd146097;
  localparam int K_1461 = 26 + $clog2(1461);
  localparam longint unsigned M_1461 = ((64'd1 << K_1461) + 64'd1460) / 64'd1461;
  localparam int K_100 = 15 + $clog2(100);
  localparam longint unsigned M_100 = ((64'd1 << K_100) + 64'd99) / 64'd100;
  localparam int K_7J = 23 + $clog2(7);
  localparam longint unsigned M_7J = ((64'd1 << K_7J) + 64'd6) / 64'd7;
  localparam int K_7S = 9 + $clog2(7);
  localparam longint unsigned M_7S = ((64'd1 << K_7S) + 64'd6) / 64'd7;
  localparam int K_153 = 11 + $clog2(153);
  localparam longint unsigned M_153 = ((64'd1 << K_153) + 64'd152) / 64'd153;

  typedef struct packed {
    logic        func;
    logic        oor;
    logic [14:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [22:0] jd;
  } date_t;

  typedef struct packed {
    logic        valid_res;
    logic [22:0] day_number;
    logic [14:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  day_of_week;
    logic [8:0]  day_of_year;
    logic [5:0]  week_number;
    logic        leap_year;
  } res_t;

  function automatic logic [7:0] div_146097(input logic [25:0] x);
    logic [52:0] p;
    p = 53'(x) * 53'(M_146097);
    return 8'(p >> K_146097);
  endfunction

  function automatic logic [15:0] div_1461(input logic [25:0] x);
    logic [52:0] p;
    p = 53'(x) * 53'(M_1461);
    return 16'(p >> K_1461);
  endfunction

  function automatic logic [7:0] div_100(input logic [14:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'(M_100);
    return 8'(p >> K_100);
  endfunction

  function automatic logic [20:0] div_7_jd(input logic [22:0] x);
    logic [47:0] p;
    p = 48'(x) * 48'(M_7J);
    return 21'(p >> K_7J);
  endfunction

  function automatic logic [6:0] div_7_small(input logic [8:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'(M_7S);
    return 7'(p >> K_7S);
  endfunction

  function automatic logic [3:0] div_153(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'(M_153);
    return 4'(p >> K_153);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     r = 5'd30;
      4'd2:                                        r = 5'd28;
      default:                                     r = 5'd0;
    endcase
    return r;
  endfunction

  // Days in the year before the first of month m, common year.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Days before month m of a year that starts in March (m = 0 is March).
  function automatic logic [8:0] march_offset(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/calendar_date_day_number_converter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_day_number_converter_core
// Converts dates to Julian day numbers and back, with weekday, day of year,
// ISO week and leap flag.
// ----------------------------------------------------------------------------
// The block takes one word per clock unless the output side stalls, and
// has nine register stages: an input register, four stages for the
// conversion and four for the calendar attributes, the last being the
// result register. Each stage holds a word until the next stage can take it,
// so a stalled output fills the empty stages before the input side is held,
// and the input is held while reset is asserted. tuser on the input selects
// the operation; tuser on the output is the valid flag, and an invalid date
// gives all fields zero.
module calendar_date_day_number_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // year[14:0], month[18:15], day[23:19],
                                  // day_number_in[46:24], zero fill
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // day_number_out[22:0], year_out[37:23],
                                  // month_out[41:38], day_out[46:42],
                                  // day_of_week[49:47], day_of_year[58:50],
                                  // week_number[64:59], leap_year[65], zero fill
  output logic        out_tuser   // valid_res
);

  localparam int NS = cdc_pkg::NUM_STAGES;

  logic [NS-1:0]  vld_r, vld_nxt;
  logic [NS-1:0]  take;
  cdc_pkg::date_t date;
  cdc_pkg::res_t  res;

  // A stage loads when it is empty or its word moves on this cycle.
  always_comb begin
    take[NS-1] = !vld_r[NS-1] || out_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      take[i] = !vld_r[i] || take[i+1];
    end
    vld_nxt[0] = take[0] ? in_tvalid : vld_r[0];
    for (int i = 1; i < NS; i++) begin
      vld_nxt[i] = take[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  cdc_front u_front (
    .clk     (clk),
    .take_i  (take[cdc_pkg::FRONT_STAGES-1:0]),
    .func_i  (in_tuser),
    .year_i  (in_tdata[14:0]),
    .month_i (in_tdata[18:15]),
    .day_i   (in_tdata[23:19]),
    .jd_i    (in_tdata[46:24]),
    .date_o  (date)
  );

  cdc_back u_back (
    .clk    (clk),
    .take_i (take[NS-1:cdc_pkg::FRONT_STAGES]),
    .date_i (date),
    .res_o  (res)
  );

  assign in_tready  = take[0] && rst_n;
  assign out_tvalid = vld_r[NS-1];
  assign out_tuser  = res.valid_res;
  assign out_tdata  = {6'd0, res.leap_year, res.week_number, res.day_of_year,
                       res.day_of_week, res.day, res.month, res.year,
                       res.day_number};

endmodule

@@ rtl/cdc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdc_front
// Input register and four stages that turn either a date into its day number
// or a day number into its date, giving a date and day number for each word.
// ----------------------------------------------------------------------------
module cdc_front (
  input  logic                                 clk,
  input  logic [cdc_pkg::FRONT_STAGES-1:0]     take_i,
  input  logic                                 func_i,
  input  logic [14:0]                          year_i,
  input  logic [3:0]                           month_i,
  input  logic [4:0]                           day_i,
  input  logic [22:0]                          jd_i,
  output cdc_pkg::date_t                       date_o
);

  // Stage 0: input register.
  logic        f0_r;
  logic [14:0] yr0_r;
  logic [3:0]  mo0_r;
  logic [4:0]  dy0_r;
  logic [22:0] jdi0_r;

  always_ff @(posedge clk) begin
    if (take_i[0]) begin
      f0_r   <= func_i;
      yr0_r  <= year_i;
      mo0_r  <= month_i;
      dy0_r  <= day_i;
      jdi0_r <= jd_i;
    end
  end

  // Stage 1: March-based year and month, century quotient, and the
  // 400-year cycle quotient for the Gregorian correction.
  logic signed [15:0] yy1, yb1;
  logic               a1;
  logic [3:0]         mm1_nxt;
  logic               greg0_nxt;
  logic [25:0]        x1;

  logic        f1_r, greg0_1_r, greg1_r, oor1_r;
  logic [14:0] yr1_r, yb1_r;
  logic [3:0]  mo1_r, mm1_r;
  logic [4:0]  dy1_r;
  logic [22:0] jdi1_r;
  logic [7:0]  q100_1_r, qc1_r;

  always_comb begin
    yy1       = $signed({yr0_r[14], yr0_r}) + $signed({15'd0, yr0_r[14]});
    a1        = (mo0_r < 4'd3);
    yb1       = yy1 + 16'sd4800 - $signed({15'd0, a1});
    mm1_nxt   = a1 ? (mo0_r + 4'd9) : (mo0_r - 4'd3);
    greg0_nxt = ($signed(yr0_r) > 15'sd1582) ||
                (($signed(yr0_r) == 15'sd1582) &&
                 ((mo0_r > 4'd10) || ((mo0_r == 4'd10) && (dy0_r >= 5'd15))));
    x1        = {1'b0, jdi0_r, 2'b00} + 26'd274277;
  end

  always_ff @(posedge clk) begin
    if (take_i[1]) begin
      f1_r      <= f0_r;
      yr1_r     <= yr0_r;
      mo1_r     <= mo0_r;
      dy1_r     <= dy0_r;
      jdi1_r    <= jdi0_r;
      yb1_r     <= yb1[14:0];
      mm1_r     <= mm1_nxt;
      q100_1_r  <= cdc_pkg::div_100(yb1[14:0]);
      greg0_1_r <= greg0_nxt;
      qc1_r     <= cdc_pkg::div_146097(x1);
      greg1_r   <= (jdi0_r >= cdc_pkg::GREG_START_JD);
      oor1_r    <= (jdi0_r > cdc_pkg::MAX_DAY_NUMBER);
    end
  end

  // Stage 2: day number of the input date; shifted Julian day count and its
  // four-year cycle quotient.
  logic [25:0] sum2, jd0w;
  logic [9:0]  q3;
  logic [23:0] jj2;
  logic [25:0] xd2;

  logic        f2_r, oor2_r;
  logic [14:0] yr2_r;
  logic [3:0]  mo2_r;
  logic [4:0]  dy2_r;
  logic [22:0] jdi2_r, jd0_2_r;
  logic [23:0] jj2_r;
  logic [15:0] dq2_r;

  always_comb begin
    sum2 = 26'(dy1_r) + 26'(cdc_pkg::march_offset(mm1_r)) +
           26'(yb1_r) * 26'd365 + 26'(yb1_r[14:2]);
    if (greg0_1_r) begin
      jd0w = sum2 - 26'(q100_1_r) + 26'(q100_1_r[7:2]) - 26'd32045;
    end else begin
      jd0w = sum2 - 26'd32083;
    end
    q3  = 10'(qc1_r) * 10'd3;
    jj2 = 24'(jdi1_r) + 24'd32082;
    if (greg1_r) begin
      jj2 = jj2 + 24'(q3[9:2]) - 24'd38;
    end
    xd2 = {jj2, 2'b11};
  end

  always_ff @(posedge clk) begin
    if (take_i[2]) begin
      f2_r    <= f1_r;
      oor2_r  <= oor1_r;
      yr2_r   <= yr1_r;
      mo2_r   <= mo1_r;
      dy2_r   <= dy1_r;
      jdi2_r  <= jdi1_r;
      jd0_2_r <= jd0w[22:0];
      jj2_r   <= jj2;
      dq2_r   <= cdc_pkg::div_1461(xd2);
    end
  end

  // Stage 3: day within the March-based year.
  logic [26:0] p3;
  logic [23:0] e3w;

  logic        f3_r, oor3_r;
  logic [14:0] yr3_r;
  logic [3:0]  mo3_r;
  logic [4:0]  dy3_r;
  logic [22:0] jdi3_r, jd0_3_r;
  logic [15:0] dq3_r;
  logic [8:0]  e3_r;

  always_comb begin
    p3  = 27'(dq2_r) * 27'd1461;
    e3w = jj2_r - 24'(p3[26:2]);
  end

  always_ff @(posedge clk) begin
    if (take_i[3]) begin
      f3_r    <= f2_r;
      oor3_r  <= oor2_r;
      yr3_r   <= yr2_r;
      mo3_r   <= mo2_r;
      dy3_r   <= dy2_r;
      jdi3_r  <= jdi2_r;
      jd0_3_r <= jd0_2_r;
      dq3_r   <= dq2_r;
      e3_r    <= e3w[8:0];
    end
  end

  // Stage 4: month, day and year of the day number; pick the result date.
  logic [3:0]         m4;
  logic               hi4;
  logic [8:0]         dd4;
  logic signed [16:0] yv4;
  cdc_pkg::date_t     date_nxt;
  cdc_pkg::date_t     date_r;

  always_comb begin
    m4  = cdc_pkg::div_153(11'(e3_r) * 11'd5 + 11'd2);
    hi4 = (m4 >= 4'd10);
    dd4 = e3_r - cdc_pkg::march_offset(m4) + 9'd1;
    yv4 = $signed({1'b0, dq3_r}) - 17'sd4800 + $signed({16'd0, hi4});
    // There is no year zero: count BC years from -1.
    if (yv4 <= 17'sd0) begin
      yv4 = yv4 - 17'sd1;
    end
    date_nxt.func = f3_r;
    if (f3_r == cdc_pkg::FUNC_JD_TO_DATE) begin
      date_nxt.oor   = oor3_r;
      date_nxt.year  = yv4[14:0];
      date_nxt.month = hi4 ? (m4 - 4'd9) : (m4 + 4'd3);
      date_nxt.day   = dd4[4:0];
      date_nxt.jd    = jdi3_r;
    end else begin
      date_nxt.oor   = 1'b0;
      date_nxt.year  = yr3_r;
      date_nxt.month = mo3_r;
      date_nxt.day   = dy3_r;
      date_nxt.jd    = jd0_3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take_i[4]) begin
      date_r <= date_nxt;
    end
  end

  assign date_o = date_r;

endmodule

@@ rtl/cdc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdc_back
// Four stages that check a date and derive its weekday, day of year, ISO
// week and leap flag; the last stage is the result register.
// ----------------------------------------------------------------------------
module cdc_back (
  input  logic                               clk,
  input  logic [cdc_pkg::BACK_STAGES-1:0]    take_i,
  input  cdc_pkg::date_t                     date_i,
  output cdc_pkg::res_t                      res_o
);

  // Stage 1: century quotient of the year and weekday quotient of the day.
  cdc_pkg::date_t d1_r;
  logic [7:0]     q100_r;
  logic [20:0]    q7_r;

  always_ff @(posedge clk) begin
    if (take_i[0]) begin
      d1_r   <= date_i;
      q100_r <= cdc_pkg::div_100(date_i.year);
      q7_r   <= cdc_pkg::div_7_jd(date_i.jd);
    end
  end

  // Stage 2: leap rules, date check, weekday and day of year.
  logic signed [14:0] y2;
  logic [14:0]        r100w;
  logic [6:0]         r100;
  logic [15:0]        yj;
  logic               gleap, pleap, jleap, leap2, greg2, gap2, dok2, ok2;
  logic [4:0]         mlen;
  logic [22:0]        wdw;
  logic [8:0]         doyg2;

  cdc_pkg::date_t d2_r;
  logic           ok2_r, leap2_r, pleap2_r, greg2_r;
  logic [2:0]     wd2_r;
  logic [8:0]     doy2_r, doyg2_r;

  always_comb begin
    y2    = $signed(d1_r.year);
    r100w = d1_r.year - 15'(q100_r) * 15'd100;
    r100  = r100w[6:0];
    gleap = (d1_r.year[1:0] == 2'd0) && ((r100 != 7'd0) || (q100_r[1:0] == 2'd0));
    // Gregorian leap flag of the year before.
    pleap = (d1_r.year[1:0] == 2'd1) && ((r100 != 7'd1) || (q100_r[1:0] == 2'd0));
    yj    = {d1_r.year[14], d1_r.year} + {15'd0, d1_r.year[14]};
    jleap = (yj[1:0] == 2'd0);
    leap2 = (y2 < 15'sd1582) ? jleap : gleap;
    greg2 = (y2 > 15'sd1582) ||
            ((y2 == 15'sd1582) && ((d1_r.month > 4'd10) ||
             ((d1_r.month == 4'd10) && (d1_r.day >= 5'd15))));
    gap2  = (y2 == 15'sd1582) && (d1_r.month == 4'd10) &&
            (d1_r.day > 5'd4) && (d1_r.day < 5'd15);
    mlen  = (d1_r.month == 4'd2) ? (leap2 ? 5'd29 : 5'd28) : cdc_pkg::month_len(d1_r.month);
    dok2  = (y2 != 15'sd0) && (y2 >= -15'sd4713) && (d1_r.month >= 4'd1) &&
            (d1_r.month <= 4'd12) && !gap2 && (d1_r.day >= 5'd1) && (d1_r.day <= mlen);
    ok2   = (d1_r.func == cdc_pkg::FUNC_JD_TO_DATE) ? !d1_r.oor : dok2;
    wdw   = d1_r.jd - 23'(q7_r) * 23'd7;
    doyg2 = cdc_pkg::days_before(d1_r.month) + 9'(d1_r.day) +
            9'(leap2 && (d1_r.month > 4'd2));
  end

  always_ff @(posedge clk) begin
    if (take_i[1]) begin
      d2_r     <= d1_r;
      ok2_r    <= ok2;
      leap2_r  <= leap2;
      pleap2_r <= pleap;
      greg2_r  <= greg2;
      wd2_r    <= wdw[2:0];
      doyg2_r  <= doyg2;
      // The year of the calendar change lost ten days in October.
      doy2_r   <= (greg2 && (y2 == 15'sd1582)) ? (doyg2 - 9'd10) : doyg2;
    end
  end

  // Stage 3: weekday of January 1 and the raw ISO week.
  logic [8:0] x1, x2;
  logic [6:0] q1, w3;
  logic [8:0] j0w;

  cdc_pkg::date_t d3_r;
  logic           ok3_r, leap3_r, pleap3_r, greg3_r;
  logic [2:0]     wd3_r, j0_r;
  logic [8:0]     doy3_r;
  logic [5:0]     w3_r;

  always_comb begin
    x1  = 9'(wd2_r) + 9'd372 - doyg2_r;
    q1  = cdc_pkg::div_7_small(x1);
    j0w = x1 - 9'(q1) * 9'd7;
    x2  = doyg2_r + 9'd9 - 9'(wd2_r);
    w3  = cdc_pkg::div_7_small(x2);
  end

  always_ff @(posedge clk) begin
    if (take_i[2]) begin
      d3_r     <= d2_r;
      ok3_r    <= ok2_r;
      leap3_r  <= leap2_r;
      pleap3_r <= pleap2_r;
      greg3_r  <= greg2_r;
      wd3_r    <= wd2_r;
      doy3_r   <= doy2_r;
      j0_r     <= j0w[2:0];
      w3_r     <= w3[5:0];
    end
  end

  // Stage 4: fold the ISO week into the neighboring years; result register.
  logic          cur53, prev53;
  logic [2:0]    dec31;
  logic [5:0]    wk;
  cdc_pkg::res_t res_nxt;
  cdc_pkg::res_t res_r;

  always_comb begin
    // A year has 53 ISO weeks when it starts on Thursday, or on Wednesday
    // in a leap year. Weekdays here count from Monday as zero.
    cur53  = (j0_r == 3'd3) || (leap3_r && (j0_r == 3'd2));
    dec31  = (j0_r == 3'd0) ? 3'd6 : (j0_r - 3'd1);
    prev53 = (dec31 == 3'd3) || (pleap3_r && (dec31 == 3'd4));
    if (!greg3_r) begin
      wk = 6'd0;
    end else if (w3_r == 6'd0) begin
      wk = prev53 ? 6'd53 : 6'd52;
    end else if ((w3_r == 6'd53) && !cur53) begin
      wk = 6'd1;
    end else begin
      wk = w3_r;
    end
    res_nxt = '0;
    if (ok3_r) begin
      res_nxt.valid_res   = 1'b1;
      res_nxt.day_number  = d3_r.jd;
      res_nxt.year        = d3_r.year;
      res_nxt.month       = d3_r.month;
      res_nxt.day         = d3_r.day;
      res_nxt.day_of_week = wd3_r + 3'd1;
      res_nxt.day_of_year = doy3_r;
      res_nxt.week_number = wk;
      res_nxt.leap_year   = leap3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take_i[3]) begin
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

@@ rtl/cdc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdc_checker
// Port-level checks on the converter's result stream.
// ----------------------------------------------------------------------------
module cdc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tuser
);

  // A word that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // A rejected date reports nothing.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 72'd0)
    else $error("invalid result carries nonzero fields");

  // An accepted date has a real month, day and weekday.
  a_valid_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[41:38] != 4'd0) && (out_tdata[41:38] <= 4'd12) &&
      (out_tdata[46:42] != 5'd0) && (out_tdata[49:47] != 3'd0))
    else $error("valid result with impossible date fields");

  // ISO weeks only exist from the Gregorian start on.
  a_week_greg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && (out_tdata[64:59] != 6'd0) |->
      $signed(out_tdata[37:23]) >= 15'sd1582)
    else $error("ISO week reported for a Julian date");

endmodule

bind calendar_date_day_number_converter_core cdc_checker u_cdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ test/calendar_date_day_number_converter_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_day_number_converter_core_test
// Self-checking bench for the date / day number converter. Words are sent with
// random bursts and gaps while the result side stalls on its own pattern, with
// one long hold-off that backs the pipeline up. Every accepted word is run
// through an independent calendar predictor, and each result is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module calendar_date_day_number_converter_core_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        out_tuser;

  cdc_pkg::res_t conversion_queue[$];
  int   mismatches;
  int   cycles;
  int   words_sent;
  int   results_seen;
  int   valid_results;
  int   jd_words;
  int   burst_left;
  bit   no_gaps;
  bit   hold_req;
  logic hold_off;

  calendar_date_day_number_converter_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------- calendar predictor ----------------

  function automatic bit is_leap(input longint y);
    longint yy;
    yy = y;
    if (yy < 1582) begin
      if (yy < 0) yy++;
      return (yy % 4) == 0;
    end
    return (yy % 400 == 0) || (yy % 4 == 0 && yy % 100 != 0);
  endfunction

  function automatic bit date_is_legal(input longint y, input longint m, input longint d);
    longint lim;
    if (y == 0 || y < -4713) return 0;
    if (m < 1 || m > 12) return 0;
    if (y == 1582 && m == 10 && d > 4 && d < 15) return 0;
    if (d < 1) return 0;
    case (m)
      2:          lim = is_leap(y) ? 29 : 28;
      4, 6, 9, 11: lim = 30;
      default:    lim = 31;
    endcase
    return d <= lim;
  endfunction

  function automatic longint day_number_of(input longint year, input longint month,
                                           input longint day);
    longint yy, a, y, m;
    bit     greg;
    yy = year < 0 ? year + 1 : year;
    a = (14 - month) / 12;
    y = yy + 4800 - a;
    m = month + 12 * a - 3;
    greg = yy > 1582 || (yy == 1582 && (month > 10 || (month == 10 && day >= 15)));
    if (greg)
      return day + (153 * m + 2) / 5 + 365 * y + y / 4 - y / 100 + y / 400 - 32045;
    return day + (153 * m + 2) / 5 + 365 * y + y / 4 - 32083;
  endfunction

  task automatic date_of_day_number(input longint jd, output longint yo,
                                    output longint mo, output longint dd);
    longint j, dg, c, dc, db, a, da, m, d, e, y;
    if (jd >= cdc_pkg::GREG_START_JD) begin
      j = jd + 32044;
      dg = j % 146097;
      c = (dg / 36524 + 1) * 3 / 4;
      dc = dg - c * 36524;
      db = dc % 1461;
      a = (db / 365 + 1) * 3 / 4;
      da = db - a * 365;
      m = (da * 5 + 308) / 153 - 2;
      yo = (j / 146097) * 400 + c * 100 + (dc / 1461) * 4 + a - 4800 + (m + 2) / 12;
      mo = (m + 2) % 12 + 1;
      dd = da - (m + 4) * 153 / 5 + 122 + 1;
    end else begin
      j = jd + 32082;
      d = (4 * j + 3) / 1461;
      e = j - (1461 * d) / 4;
      m = (5 * e + 2) / 153;
      y = d - 4800 + m / 10;
      dd = e - (153 * m + 2) / 5 + 1;
      mo = m + 3 - 12 * (m / 10);
      if (y <= 0) y--;
      yo = y;
    end
  endtask

  function automatic longint iso_week_of(input longint y, input longint mo, input longint d);
    longint a, b, c, s, e, f, g, dd, n;
    if (y < 1582 || (y == 1582 && (mo < 10 || (mo == 10 && d < 15)))) return 0;
    a = (mo < 3) ? y - 1 : y;
    b = a / 4 - a / 100 + a / 400;
    c = (a - 1) / 4 - (a - 1) / 100 + (a - 1) / 400;
    s = b - c;
    if (mo < 3) begin
      e = 0;
      f = d - 1 + 31 * (mo - 1);
    end else begin
      e = s + 1;
      f = d + (153 * (mo - 3) + 2) / 5 + 58 + s;
    end
    g = (a + b) % 7;
    dd = (f + g - e) % 7;
    n = f + 3 - dd;
    if (n < 0) return 53 - (g - s) / 5;
    if (n > 364 + s) return 1;
    return n / 7 + 1;
  endfunction

  task automatic predict_conversion(input logic [47:0] word, input logic op,
                                    output cdc_pkg::res_t r);
    longint y, m, d, jd;
    r = '0;
    if (op == cdc_pkg::FUNC_DATE_TO_JD) begin
      y = longint'($signed(word[14:0]));
      m = word[18:15];
      d = word[23:19];
      if (!date_is_legal(y, m, d)) return;
    end else begin
      jd = word[46:24];
      if (jd > cdc_pkg::MAX_DAY_NUMBER) return;
      date_of_day_number(jd, y, m, d);
      if (!date_is_legal(y, m, d)) return;
    end
    jd = day_number_of(y, m, d);
    r.valid_res   = 1'b1;
    r.day_number  = jd[22:0];
    r.year        = y[14:0];
    r.month       = m[3:0];
    r.day         = d[4:0];
    r.day_of_week = 3'(jd % 7 + 1);
    r.day_of_year = 9'(jd - day_number_of(y, 1, 1) + 1);
    r.week_number = 6'(iso_week_of(y, m, d));
    r.leap_year   = is_leap(y);
  endtask

  // ---------------- monitors ----------------

  function automatic void compare_field(input string name, input longint want,
                                        input longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result %0d, %s: expected %0d, got %0d",
                 results_seen, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    cdc_pkg::res_t want;
    cdc_pkg::res_t fresh;
    if (rst_n && out_tvalid && out_tready) begin
      if (conversion_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word with nothing expected");
      end else begin
        want = conversion_queue.pop_front();
        compare_field("valid_res", want.valid_res, out_tuser);
        compare_field("day_number_out", want.day_number, out_tdata[22:0]);
        compare_field("year_out", want.year, out_tdata[37:23]);
        compare_field("month_out", want.month, out_tdata[41:38]);
        compare_field("day_out", want.day, out_tdata[46:42]);
        compare_field("day_of_week", want.day_of_week, out_tdata[49:47]);
        compare_field("day_of_year", want.day_of_year, out_tdata[58:50]);
        compare_field("week_number", want.week_number, out_tdata[64:59]);
        compare_field("leap_year", want.leap_year, out_tdata[65]);
        if (want.valid_res) valid_results++;
      end
      results_seen++;
    end
    if (rst_n && in_tvalid && in_tready) begin
      predict_conversion(in_tdata, in_tuser, fresh);
      conversion_queue.push_back(fresh);
      if (in_tuser == cdc_pkg::FUNC_JD_TO_DATE) jd_words++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("calendar_date_day_number_converter_core_test: errors");
      $finish;
    end
  end

  // Receiver: rotates through always-ready, coin-flip and mostly-stalled phases.
  always @(posedge clk) begin
    logic ready_now;
    case ((cycles / 97) % 3)
      0:       ready_now = 1'b1;
      1:       ready_now = $urandom_range(0, 1);
      default: ready_now = ($urandom_range(0, 3) == 0);
    endcase
    out_tready <= rst_n && !hold_off && ready_now;
  end

  initial begin
    hold_off = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
        hold_req = 1'b0;
      end
    end
  end

  // ---------------- stimulus ----------------

  task automatic send_word(input logic op, input logic signed [14:0] y, input logic [3:0] m,
                           input logic [4:0] d, input logic [22:0] jin);
    in_tdata  <= {1'b0, jin, d, m, y};
    in_tuser  <= op;
    in_tvalid <= 1'b1;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    words_sent++;
    if (no_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic send_date(input int y, input int m, input int d);
    send_word(cdc_pkg::FUNC_DATE_TO_JD, 15'(y), 4'(m), 5'(d), 23'($urandom));
  endtask

  task automatic send_day_number(input int jd);
    send_word(cdc_pkg::FUNC_JD_TO_DATE, 15'($urandom), 4'($urandom), 5'($urandom),
              23'(jd));
  endtask

  task automatic drain_results;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (conversion_queue.size() != 0) @(posedge clk);
    repeat (2 * cdc_pkg::NUM_STAGES) @(posedge clk);
  endtask

  task automatic test_date_edges;
    send_date(-4713, 1, 1);
    send_date(-4714, 12, 31);
    send_date(-16384, 1, 1);
    send_date(0, 6, 15);
    send_date(-1, 2, 29);       // 1 BC is a Julian leap year
    send_date(1500, 2, 29);
    send_date(1900, 2, 29);
    send_date(2000, 2, 29);
    send_date(2001, 2, 29);
    send_date(1582, 10, 4);
    send_date(1582, 10, 5);
    send_date(1582, 10, 14);
    send_date(1582, 10, 15);
    send_date(2023, 0, 10);
    send_date(2023, 13, 10);
    send_date(2023, 15, 31);
    send_date(2023, 4, 31);
    send_date(2023, 6, 0);
    send_date(2004, 12, 31);    // ISO week 53 at year end
    send_date(2005, 1, 1);
    send_date(2008, 12, 29);    // ISO week 1 of the next year
    send_date(9999, 12, 31);
    send_date(16383, 12, 31);
  endtask

  task automatic test_day_number_edges;
    send_day_number(0);
    send_day_number(2299160);
    send_day_number(2299161);
    send_day_number(5373484);
    send_day_number(5373485);
    send_day_number(23'h7FFFFF);
  endtask

  task automatic send_random_item;
    int kind;
    int y;
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      case ($urandom_range(0, 3))
        0:       y = $urandom_range(1, 9999);
        1:       y = -int'($urandom_range(1, 4713));
        2:       y = $urandom_range(1570, 1600);
        default: y = int'($signed(15'($urandom)));
      endcase
      if ($urandom_range(0, 7) == 0)
        send_date(y, $urandom_range(0, 15), $urandom_range(0, 31));
      else
        send_date(y, $urandom_range(1, 12), $urandom_range(1, 31));
    end else if (kind < 9) begin
      if ($urandom_range(0, 3) == 0)
        send_day_number($urandom_range(2299100, 2299220));
      else
        send_day_number($urandom_range(0, 5373484));
    end else begin
      send_day_number($urandom_range(0, 23'h7FFFFF));
    end
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_random_item();
  endtask

  task automatic test_backpressure;
    no_gaps = 1'b1;
    hold_req = 1'b1;
    repeat (60) send_random_item();
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= 1'b0;
    out_tready <= 1'b0;
    hold_req   = 1'b0;
    no_gaps    = 1'b0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_date_edges();
    test_day_number_edges();
    test_random_traffic(400);
    test_backpressure();
    test_random_traffic(400);
    drain_results();

    $display("%0d words sent, %0d of them day numbers; %0d results checked, %0d valid.",
             words_sent, jd_words, results_seen, valid_results);
    $display("%0d cycles, %0d field mismatches.", cycles, mismatches);
    if (mismatches == 0 && conversion_queue.size() == 0)
      $display("calendar_date_day_number_converter_core_test: clean");
    else
      $display("calendar_date_day_number_converter_core_test: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/cdc_pkg.sv
rtl/cdc_front.sv
rtl/cdc_back.sv
rtl/calendar_date_day_number_converter_core.sv
rtl/cdc_checker.sv
test/calendar_date_day_number_converter_core_test.sv
